/* rtl/core/sat_pkg.sv */
// section address translator: shared types and constants
// used by sat_engine and section_address_translator; no dependencies
`timescale 1ns / 1ps

package sat_pkg;

    // configuration register indexes
    localparam int unsigned CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_SECTION_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAPPING_BASE  = 1'b1;

    localparam int unsigned COUNT_W = 5;
    localparam int unsigned ADDR_W  = 32;

    // command codes of the input word
    typedef enum logic [2:0] {
        CMD_LOAD          = 3'd0,
        CMD_RVA_TO_OFFSET = 3'd1,
        CMD_RVA_TO_MAPPED = 3'd2,
        CMD_OFFSET_TO_RVA = 3'd3,
        CMD_MAPPED_TO_RVA = 3'd4,
        CMD_SECTION_START = 3'd5,
        CMD_RAW_TOTAL     = 3'd6
    } command_t;

    // one section table entry as held in the table memory
    typedef struct packed {
        logic [ADDR_W-1:0] virtual_start;
        logic [ADDR_W-1:0] raw_length;
        logic [ADDR_W-1:0] raw_position;
    } entry_t;

    localparam int unsigned ENTRY_W = $bits(entry_t);

    // configuration register contents
    typedef struct packed {
        logic [COUNT_W-1:0] section_count;
        logic [ADDR_W-1:0]  mapping_base;
    } cfg_t;

endpackage

/* rtl/core/sat_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module sat_ram #(
    parameter int unsigned WIDTH = 96,
    parameter int unsigned DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/sat_engine.sv */
// section address translator: command sequencer that loads and scans the table
// depends on sat_pkg; drives the table memory held by the top level
`timescale 1ns / 1ps

module sat_engine #(
    parameter int unsigned MAX_SECTIONS = 16
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  sat_pkg::cfg_t                               cfg,
    input  logic                                        in_valid,
    output logic                                        in_stall,
    input  logic [2:0]                                  command,
    input  logic [3:0]                                  entry_index,
    input  logic [31:0]                                 virtual_start,
    input  logic [31:0]                                 raw_length,
    input  logic [31:0]                                 raw_position,
    input  logic [31:0]                                 query_value,
    output logic                                        out_valid,
    input  logic                                        out_stall,
    output logic [31:0]                                 result_value,
    output logic                                        found,
    output logic                                        ram_wr_en,
    output logic [$clog2(MAX_SECTIONS > 1 ? MAX_SECTIONS : 2)-1:0] ram_wr_addr,
    output sat_pkg::entry_t                             ram_wr_data,
    output logic [$clog2(MAX_SECTIONS > 1 ? MAX_SECTIONS : 2)-1:0] ram_rd_addr,
    input  sat_pkg::entry_t                             ram_rd_data
);

    localparam int unsigned AW   = $clog2(MAX_SECTIONS > 1 ? MAX_SECTIONS : 2);
    localparam int unsigned CW   = $clog2(MAX_SECTIONS + 1);
    localparam int unsigned IXW  = (AW > 4) ? AW : 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_CALC,
        S_HOLD
    } state_t;

    state_t                      state_reg, state_next;
    sat_pkg::command_t           cmd_reg, cmd_next;
    logic [31:0]                 q_reg, q_next;
    logic [CW-1:0]               n_reg, n_next;
    logic [CW-1:0]               addr_reg, addr_next;
    logic [CW-1:0]               data_idx_reg, data_idx_next;
    logic                        data_valid_reg, data_valid_next;
    logic                        has_prev_reg, has_prev_next;
    logic [31:0]                 prev_vs_reg, prev_vs_next;
    logic [31:0]                 prev_len_reg, prev_len_next;
    logic [31:0]                 sum_reg, sum_next;
    sat_pkg::entry_t             cap_reg, cap_next;
    logic [31:0]                 res_reg, res_next;
    logic                        hit_reg, hit_next;
    logic                        out_valid_reg, out_valid_next;
    logic [31:0]                 out_value_reg, out_value_next;
    logic                        out_found_reg, out_found_next;

    sat_pkg::command_t           in_cmd;
    logic [CW-1:0]               n_sat;
    logic [IXW-1:0]              idx_ext;
    logic                        rd_en;
    logic                        is_range;
    logic                        is_virtual;
    logic                        last;
    logic [31:0]                 key_start;
    logic [31:0]                 range_end;
    logic                        range_hit;
    logic                        prev_hit;
    logic                        tail_hit;
    logic [31:0]                 acc;
    logic [31:0]                 cap_key;
    logic [31:0]                 cap_other;
    logic [31:0]                 base_term;
    logic [31:0]                 calc;

    // decode of the incoming word and the saturated search count
    assign in_cmd  = sat_pkg::command_t'(command);
    assign n_sat   = (32'(cfg.section_count) > 32'(MAX_SECTIONS))
                     ? CW'(MAX_SECTIONS) : CW'(cfg.section_count);
    assign idx_ext = IXW'(entry_index);

    // table write on an accepted load word
    assign ram_wr_en   = (state_reg == S_IDLE) && in_valid
                         && (in_cmd == sat_pkg::CMD_LOAD)
                         && (32'(entry_index) < 32'(MAX_SECTIONS));
    assign ram_wr_addr = idx_ext[AW-1:0];
    assign ram_wr_data = '{virtual_start: virtual_start,
                           raw_length:    raw_length,
                           raw_position:  raw_position};

    // table read, one entry per cycle while scanning
    assign rd_en       = (state_reg == S_SCAN) && (addr_reg < n_reg);
    assign ram_rd_addr = rd_en ? addr_reg[AW-1:0] : '0;

    // compare of the entry that just came out of the table
    assign is_range   = (cmd_reg == sat_pkg::CMD_RVA_TO_OFFSET)
                        || (cmd_reg == sat_pkg::CMD_RVA_TO_MAPPED)
                        || (cmd_reg == sat_pkg::CMD_OFFSET_TO_RVA)
                        || (cmd_reg == sat_pkg::CMD_MAPPED_TO_RVA);
    assign is_virtual = (cmd_reg == sat_pkg::CMD_RVA_TO_OFFSET)
                        || (cmd_reg == sat_pkg::CMD_RVA_TO_MAPPED);
    assign last       = ((CW + 1)'(data_idx_reg) + (CW + 1)'(1)) == (CW + 1)'(n_reg);
    assign key_start  = is_virtual ? ram_rd_data.virtual_start : ram_rd_data.raw_position;
    assign range_end  = key_start + ram_rd_data.raw_length;
    assign range_hit  = (key_start <= q_reg) && (range_end > q_reg);
    assign prev_hit   = has_prev_reg && (prev_vs_reg <= q_reg)
                        && (ram_rd_data.virtual_start > q_reg);
    assign tail_hit   = last && (ram_rd_data.virtual_start <= q_reg);
    assign acc        = sum_reg + (has_prev_reg ? prev_len_reg : 32'd0);

    // translation of the captured matching entry
    assign cap_key   = is_virtual ? cap_reg.virtual_start : cap_reg.raw_position;
    assign cap_other = is_virtual ? cap_reg.raw_position : cap_reg.virtual_start;
    assign base_term = (cmd_reg == sat_pkg::CMD_RVA_TO_MAPPED) ? cfg.mapping_base : 32'd0;
    assign calc      = cap_other + (q_reg - cap_key) + base_term;

    // next state and datapath values
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        q_next          = q_reg;
        n_next          = n_reg;
        addr_next       = addr_reg;
        data_idx_next   = data_idx_reg;
        data_valid_next = 1'b0;
        has_prev_next   = has_prev_reg;
        prev_vs_next    = prev_vs_reg;
        prev_len_next   = prev_len_reg;
        sum_next        = sum_reg;
        cap_next        = cap_reg;
        res_next        = res_reg;
        hit_next        = hit_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_value_next  = out_value_reg;
        out_found_next  = out_found_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next      = in_cmd;
                    q_next        = (in_cmd == sat_pkg::CMD_MAPPED_TO_RVA)
                                    ? query_value - cfg.mapping_base : query_value;
                    n_next        = n_sat;
                    addr_next     = '0;
                    has_prev_next = 1'b0;
                    sum_next      = '0;
                    res_next      = '0;
                    hit_next      = 1'b0;
                    case (in_cmd)
                        sat_pkg::CMD_RVA_TO_OFFSET,
                        sat_pkg::CMD_RVA_TO_MAPPED,
                        sat_pkg::CMD_OFFSET_TO_RVA,
                        sat_pkg::CMD_MAPPED_TO_RVA,
                        sat_pkg::CMD_SECTION_START,
                        sat_pkg::CMD_RAW_TOTAL:
                        begin
                            state_next = (n_sat == '0) ? S_HOLD : S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_HOLD;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (rd_en)
                begin
                    addr_next       = addr_reg + CW'(1);
                    data_idx_next   = addr_reg;
                    data_valid_next = 1'b1;
                end
                if (data_valid_reg)
                begin
                    if (is_range)
                    begin
                        if (range_hit)
                        begin
                            cap_next   = ram_rd_data;
                            state_next = S_CALC;
                        end
                        else if (last)
                        begin
                            state_next = S_HOLD;
                        end
                    end
                    else
                    begin
                        priority if (prev_hit)
                        begin
                            res_next   = (cmd_reg == sat_pkg::CMD_SECTION_START)
                                         ? prev_vs_reg : sum_reg;
                            hit_next   = 1'b1;
                            state_next = S_HOLD;
                        end
                        else if (tail_hit)
                        begin
                            res_next   = (cmd_reg == sat_pkg::CMD_SECTION_START)
                                         ? ram_rd_data.virtual_start : acc;
                            hit_next   = 1'b1;
                            state_next = S_HOLD;
                        end
                        else if (last)
                        begin
                            state_next = S_HOLD;
                        end
                        else
                        begin
                            sum_next      = acc;
                            prev_vs_next  = ram_rd_data.virtual_start;
                            prev_len_next = ram_rd_data.raw_length;
                            has_prev_next = 1'b1;
                        end
                    end
                end
                if (state_next != S_SCAN)
                begin
                    data_valid_next = 1'b0;
                end
            end
            S_CALC:
            begin
                res_next   = calc;
                hit_next   = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    out_found_next = hit_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= sat_pkg::CMD_LOAD;
            q_reg          <= '0;
            n_reg          <= '0;
            addr_reg       <= '0;
            data_idx_reg   <= '0;
            data_valid_reg <= 1'b0;
            has_prev_reg   <= 1'b0;
            prev_vs_reg    <= '0;
            prev_len_reg   <= '0;
            sum_reg        <= '0;
            cap_reg        <= '0;
            res_reg        <= '0;
            hit_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            q_reg          <= q_next;
            n_reg          <= n_next;
            addr_reg       <= addr_next;
            data_idx_reg   <= data_idx_next;
            data_valid_reg <= data_valid_next;
            has_prev_reg   <= has_prev_next;
            prev_vs_reg    <= prev_vs_next;
            prev_len_reg   <= prev_len_next;
            sum_reg        <= sum_next;
            cap_reg        <= cap_next;
            res_reg        <= res_next;
            hit_reg        <= hit_next;
            out_valid_reg  <= out_valid_next;
            out_value_reg  <= out_value_next;
            out_found_reg  <= out_found_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = out_value_reg;
    assign found        = out_found_reg;

`ifndef SYNTH
    // table writes never overlap a scan
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg == S_IDLE))
        else $error("table write outside idle");

    // read pointer never passes the searched count
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (addr_reg <= n_reg))
        else $error("scan pointer past section count");

    // returned table data always belongs to a searched entry
    assert property (@(posedge clk) disable iff (!rst_n)
        data_valid_reg |-> ((state_reg == S_SCAN) && (data_idx_reg < n_reg)))
        else $error("table data outside scan");

    // a finished result moves into a free output register
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_HOLD) && !out_stall) |=> (out_valid_reg && (state_reg == S_IDLE)))
        else $error("result not delivered to output register");
`endif

endmodule

/* rtl/core/section_address_translator.sv */
// section address translator top level: configuration registers, table memory
// depends on sat_pkg, sat_ram and sat_engine
`timescale 1ns / 1ps

// Translates between relative virtual addresses, file offsets and mapped
// addresses using a section table of up to MAX_SECTIONS entries held in one
// synchronous memory (virtual start, raw size, raw position per entry). A load
// word writes one entry and returns a zero result. With n the searched count
// (section_count, capped at MAX_SECTIONS), a query word searches entries 0 to
// n - 1 in order, reading the table one entry per cycle through its single
// read port. A range query that matches passes through a calculate step
// before its result is held; every other query is held at a match or after
// the last entry. A load, an unused command or a query with a count of zero
// goes straight to the hold step. The next word is accepted in the cycle
// after the result enters the output register, and the result waits in the
// engine while the output register is still held. One word is in work at a
// time; a finished result waits in the output register while the next word is
// accepted. Configuration writes (section_count, mapping_base) are always
// ready and are to be issued while no word is in work.
module section_address_translator #(
    parameter int unsigned MAX_SECTIONS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [sat_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        command,
    input  logic [3:0]                        entry_index,
    input  logic [31:0]                       virtual_start,
    input  logic [31:0]                       raw_length,
    input  logic [31:0]                       raw_position,
    input  logic [31:0]                       query_value,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [31:0]                       result_value,
    output logic                              found
);

    localparam int unsigned AW = $clog2(MAX_SECTIONS > 1 ? MAX_SECTIONS : 2);

    sat_pkg::cfg_t   cfg_reg;
    logic            ram_wr_en;
    logic [AW-1:0]   ram_wr_addr;
    sat_pkg::entry_t ram_wr_data;
    logic [AW-1:0]   ram_rd_addr;
    sat_pkg::entry_t ram_rd_data;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                sat_pkg::REG_SECTION_COUNT:
                begin
                    cfg_reg.section_count <= cfg_data[sat_pkg::COUNT_W-1:0];
                end
                sat_pkg::REG_MAPPING_BASE:
                begin
                    cfg_reg.mapping_base <= cfg_data;
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // section table memory
    sat_ram #(
        .WIDTH (sat_pkg::ENTRY_W),
        .DEPTH (MAX_SECTIONS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // command sequencer
    sat_engine #(
        .MAX_SECTIONS (MAX_SECTIONS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .command       (command),
        .entry_index   (entry_index),
        .virtual_start (virtual_start),
        .raw_length    (raw_length),
        .raw_position  (raw_position),
        .query_value   (query_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_value  (result_value),
        .found         (found),
        .ram_wr_en     (ram_wr_en),
        .ram_wr_addr   (ram_wr_addr),
        .ram_wr_data   (ram_wr_data),
        .ram_rd_addr   (ram_rd_addr),
        .ram_rd_data   (ram_rd_data)
    );

endmodule

/* tb/sv/sat_translation_check.sv */
// section address translator testbench: checker that predicts every result word
// watches the config, input and output channels; depends on sat_pkg
`timescale 1ns / 1ps

module sat_translation_check #(
    parameter int unsigned MAX_SECTIONS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sat_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]                     cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  logic [2:0]                      command,
    input  logic [3:0]                      entry_index,
    input  logic [31:0]                     virtual_start,
    input  logic [31:0]                     raw_length,
    input  logic [31:0]                     raw_position,
    input  logic [31:0]                     query_value,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  logic [31:0]                     result_value,
    input  logic                            found,
    output int unsigned                     mismatches,
    output int unsigned                     pending,
    output int unsigned                     checked
);

    localparam int unsigned REPORT_LIMIT = 10;

    // one expected result word, with the query that caused it
    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] query;
        logic [31:0] value;
        logic        hit;
    } translation_t;

    translation_t expected_translations[$];

    // private copy of the section table and the registers
    logic [31:0]                 sec_virtual_start [MAX_SECTIONS];
    logic [31:0]                 sec_raw_length    [MAX_SECTIONS];
    logic [31:0]                 sec_raw_position  [MAX_SECTIONS];
    logic [sat_pkg::COUNT_W-1:0] count_reg;
    logic [31:0]                 base_reg;

    translation_t       oldest;

    // counts above the table size saturate
    function automatic int searched_count();
        return (count_reg > MAX_SECTIONS) ? MAX_SECTIONS : int'(count_reg);
    endfunction

    // lowest slot whose virtual or raw range holds v, -1 if none
    function automatic int find_span(input logic [31:0] v, input bit by_raw);
        int          n;
        logic [31:0] lo;
        logic [31:0] hi;
        n = searched_count();
        for (int i = 0; i < n; i++)
        begin
            lo = by_raw ? sec_raw_position[i] : sec_virtual_start[i];
            hi = lo + sec_raw_length[i];
            if (lo <= v && hi > v)
                return i;
        end
        return -1;
    endfunction

    // containing slot by consecutive starts, the last one unbounded
    function automatic int find_containing(input logic [31:0] v);
        int n;
        n = searched_count();
        for (int i = 0; i < n; i++)
        begin
            if (sec_virtual_start[i] <= v && (i + 1 == n || sec_virtual_start[i + 1] > v))
                return i;
        end
        return -1;
    endfunction

    // work out the result of one accepted input word
    task automatic predict_word();
        translation_t t;
        int           k;
        logic [31:0]  q;
        t.cmd   = command;
        t.query = query_value;
        t.value = '0;
        t.hit   = 1'b0;
        q       = query_value;
        case (command)
            sat_pkg::CMD_LOAD:
            begin
                if (entry_index < MAX_SECTIONS)
                begin
                    sec_virtual_start[entry_index] = virtual_start;
                    sec_raw_length[entry_index]    = raw_length;
                    sec_raw_position[entry_index]  = raw_position;
                end
            end
            sat_pkg::CMD_RVA_TO_OFFSET, sat_pkg::CMD_RVA_TO_MAPPED:
            begin
                k = find_span(q, 1'b0);
                if (k >= 0)
                begin
                    t.value = sec_raw_position[k] + (q - sec_virtual_start[k]);
                    if (command == sat_pkg::CMD_RVA_TO_MAPPED)
                        t.value = t.value + base_reg;
                    t.hit = 1'b1;
                end
            end
            sat_pkg::CMD_OFFSET_TO_RVA, sat_pkg::CMD_MAPPED_TO_RVA:
            begin
                if (command == sat_pkg::CMD_MAPPED_TO_RVA)
                    q = q - base_reg;
                k = find_span(q, 1'b1);
                if (k >= 0)
                begin
                    t.value = sec_virtual_start[k] + (q - sec_raw_position[k]);
                    t.hit   = 1'b1;
                end
            end
            sat_pkg::CMD_SECTION_START:
            begin
                k = find_containing(q);
                if (k >= 0)
                begin
                    t.value = sec_virtual_start[k];
                    t.hit   = 1'b1;
                end
            end
            sat_pkg::CMD_RAW_TOTAL:
            begin
                k = find_containing(q);
                if (k >= 0)
                begin
                    for (int i = 0; i < k; i++)
                        t.value = t.value + sec_raw_length[i];
                    t.hit = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
        expected_translations.push_back(t);
    endtask

    // watch all three channels at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_translations.delete();
            for (int i = 0; i < MAX_SECTIONS; i++)
            begin
                sec_virtual_start[i] = '0;
                sec_raw_length[i]    = '0;
                sec_raw_position[i]  = '0;
            end
            count_reg  = '0;
            base_reg   = '0;
            mismatches = 0;
            checked    = 0;
            pending    = 0;
        end
        else
        begin
            // register writes
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == sat_pkg::REG_SECTION_COUNT)
                    count_reg = cfg_data[sat_pkg::COUNT_W-1:0];
                else if (cfg_index == sat_pkg::REG_MAPPING_BASE)
                    base_reg = cfg_data;
            end

            // result word against the oldest expectation
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_translations.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result value %h found %b with nothing expected",
                                 $realtime, result_value, found);
                end
                else
                begin
                    oldest = expected_translations.pop_front();
                    if (result_value !== oldest.value || found !== oldest.hit)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: cmd %0d query %h: expected %h %b, got %h %b",
                                     $realtime, oldest.cmd, oldest.query, oldest.value,
                                     oldest.hit, result_value, found);
                    end
                end
            end

            // input word
            if (in_valid && !in_stall)
                predict_word();

            pending = expected_translations.size();
        end
    end

endmodule

/* tb/sv/tb_section_address_translator.sv */
// section address translator testbench top: clock, reset, stimulus and verdict
// depends on sat_pkg, section_address_translator and sat_translation_check
`timescale 1ns / 1ps

module tb_section_address_translator;

    localparam int unsigned MAX_SECTIONS  = 16;
    localparam logic [2:0]  CMD_UNUSED    = 3'd7;
    localparam int unsigned TOTAL_WORDS   = 1130;
    localparam int unsigned PHASE_QUERIES = 40;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned CYCLE_LIMIT   = 600000;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [sat_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [31:0]                     cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    logic [2:0]                      command;
    logic [3:0]                      entry_index;
    logic [31:0]                     virtual_start;
    logic [31:0]                     raw_length;
    logic [31:0]                     raw_position;
    logic [31:0]                     query_value;
    logic                            out_valid;
    logic                            out_stall;
    logic [31:0]                     result_value;
    logic                            found;

    int unsigned mismatches;
    int unsigned pending;
    int unsigned checked;

    // stimulus bookkeeping
    int unsigned words_sent;
    int unsigned loads_sent;
    int unsigned phase_count;
    int unsigned cycle_count;
    int unsigned hold_asked;
    int unsigned hold_done;
    bit          quiet;
    logic [31:0] cur_base;

    // layout of the loaded image, used to aim queries and nudged reloads
    logic [31:0] img_vs  [MAX_SECTIONS];
    logic [31:0] img_len [MAX_SECTIONS];
    logic [31:0] img_pos [MAX_SECTIONS];

    section_address_translator #(
        .MAX_SECTIONS(MAX_SECTIONS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .entry_index  (entry_index),
        .virtual_start(virtual_start),
        .raw_length   (raw_length),
        .raw_position (raw_position),
        .query_value  (query_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .found        (found)
    );

    sat_translation_check #(
        .MAX_SECTIONS(MAX_SECTIONS)
    ) i_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .entry_index  (entry_index),
        .virtual_start(virtual_start),
        .raw_length   (raw_length),
        .raw_position (raw_position),
        .query_value  (query_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_value (result_value),
        .found        (found),
        .mismatches   (mismatches),
        .pending      (pending),
        .checked      (checked)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // idle cycles before one word, none in quiet stretches
    function automatic int idle_draw();
        return quiet ? 0 : int'($urandom_range(0, 10));
    endfunction

    // offer one input word and wait until it is taken
    task automatic push_word(input logic [2:0] cmd, input logic [3:0] slot,
                             input logic [31:0] vstart, input logic [31:0] rlen,
                             input logic [31:0] rpos, input logic [31:0] qval);
        int gap;
        gap = idle_draw();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        command       = cmd;
        entry_index   = slot;
        virtual_start = vstart;
        raw_length    = rlen;
        raw_position  = rpos;
        query_value   = qval;
        in_valid      = 1'b1;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    // load one table entry and remember the layout
    task automatic load_entry(input logic [3:0] slot, input logic [31:0] vstart,
                              input logic [31:0] rlen, input logic [31:0] rpos);
        img_vs[slot]  = vstart;
        img_len[slot] = rlen;
        img_pos[slot] = rpos;
        loads_sent++;
        push_word(sat_pkg::CMD_LOAD, slot, vstart, rlen, rpos, $urandom);
    endtask

    task automatic query(input logic [2:0] cmd, input logic [31:0] qval);
        push_word(cmd, 4'($urandom_range(0, 15)), $urandom, $urandom, $urandom, qval);
    endtask

    // stop offering and wait until every expected result has come back
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [sat_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [31:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // new register setting for one phase, extremes in the first two
    task automatic settle_registers(input int unsigned phase);
        logic [31:0] cnt;
        case ($urandom_range(0, 7))
            0:       cnt = 0;
            1:       cnt = 1;
            2, 3:    cnt = MAX_SECTIONS;
            4:       cnt = $urandom_range(MAX_SECTIONS + 1, 31);
            default: cnt = $urandom_range(0, MAX_SECTIONS);
        endcase
        if (phase == 0)
            cnt = MAX_SECTIONS;
        else if (phase == 1)
            cnt = 0;
        case ($urandom_range(0, 3))
            0:       cur_base = '0;
            1:       cur_base = 32'hFFFF_FFFF;
            default: cur_base = $urandom;
        endcase
        if ($urandom_range(0, 1))
        begin
            cfg_write(sat_pkg::REG_SECTION_COUNT, cnt);
            cfg_write(sat_pkg::REG_MAPPING_BASE, cur_base);
        end
        else
        begin
            cfg_write(sat_pkg::REG_MAPPING_BASE, cur_base);
            cfg_write(sat_pkg::REG_SECTION_COUNT, cnt);
        end
    endtask

    // load all slots: ascending sections with gaps and overlaps, or noise
    task automatic build_image(input bit noisy);
        logic [31:0] v;
        logic [31:0] p;
        logic [31:0] len;
        v = ($urandom_range(0, 3) != 0) ? 32'($urandom_range(0, 32'h1_0000))
                                        : 32'hFFFF_0000 + $urandom_range(0, 32'h8000);
        p = $urandom_range(0, 1) ? 32'($urandom_range(0, 32'h4000)) : 32'($urandom);
        for (int i = 0; i < MAX_SECTIONS; i++)
        begin
            len = ($urandom_range(0, 9) == 0) ? 32'd0 : 32'($urandom_range(1, 32'h3000));
            if (noisy)
                load_entry(4'(i), $urandom, $urandom, $urandom);
            else
                load_entry(4'(i), v, len, p);
            if ($urandom_range(0, 7) == 0)
                v = v + len / 2;
            else
                v = v + len + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32'h1000));
            p = p + len + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 32'h800));
        end
    endtask

    // one random word aimed at, around or off a section
    task automatic random_word();
        int unsigned k;
        int unsigned pick;
        logic [2:0]  cmd;
        logic [31:0] off;
        logic [31:0] q;
        pick = $urandom_range(0, 19);
        k    = $urandom_range(0, MAX_SECTIONS - 1);
        if (pick < 2)
        begin
            // reload a slot, nudged or with noise
            if (pick == 0)
                load_entry(4'(k), img_vs[k] + $urandom_range(0, 32'h100), img_len[k], img_pos[k]);
            else
                load_entry(4'(k), $urandom, $urandom, $urandom);
        end
        else
        begin
            cmd = (pick == 2) ? CMD_UNUSED : 3'($urandom_range(1, 6));
            case ($urandom_range(0, 7))
                0:       off = 32'hFFFF_FFFF;
                1:       off = img_len[k];
                default: off = (img_len[k] == 0) ? 32'd0 : 32'($urandom_range(0, img_len[k] - 1));
            endcase
            if (cmd == sat_pkg::CMD_OFFSET_TO_RVA || cmd == sat_pkg::CMD_MAPPED_TO_RVA)
                q = img_pos[k] + off;
            else
                q = img_vs[k] + off;
            if (cmd == sat_pkg::CMD_MAPPED_TO_RVA)
                q = q + cur_base;
            if ($urandom_range(0, 9) == 0)
                q = $urandom;
            query(cmd, q);
        end
    endtask

    // receiver: random stall per word, a long hold-off on request
    initial
    begin
        int wait_cycles;
        out_stall = 1'b0;
        wait (rst_n);
        forever
        begin
            wait_cycles = idle_draw();
            if (hold_done != hold_asked)
            begin
                hold_done   = hold_asked;
                wait_cycles = HOLD_CYCLES;
            end
            if (wait_cycles > 0)
            begin
                @(negedge clk);
                out_stall = 1'b1;
                repeat (wait_cycles - 1) @(negedge clk);
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("watchdog: run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("tb_section_address_translator: errors");
        $finish;
    end

    // reset, directed words, random phases, verdict
    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        command       = sat_pkg::CMD_LOAD;
        entry_index   = '0;
        virtual_start = '0;
        raw_length    = '0;
        raw_position  = '0;
        query_value   = '0;
        words_sent    = 0;
        loads_sent    = 0;
        phase_count   = 0;
        hold_asked    = 0;
        hold_done     = 0;
        quiet         = 1'b0;
        cur_base      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty search set: nothing can match
        query(sat_pkg::CMD_RVA_TO_OFFSET, 32'h0);
        query(sat_pkg::CMD_RAW_TOTAL, 32'hFFFF_FFFF);
        push_word(CMD_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // regular table, last slot at the top with a wrapping range
        for (int i = 0; i < MAX_SECTIONS - 1; i++)
            load_entry(4'(i), 32'(i) * 32'h1000, 32'h800, 32'h400 + 32'(i) * 32'h800);
        load_entry(4'hF, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        cfg_write(sat_pkg::REG_SECTION_COUNT, MAX_SECTIONS);
        cur_base = 32'hFFFF_FFFF;
        cfg_write(sat_pkg::REG_MAPPING_BASE, cur_base);

        query(sat_pkg::CMD_RVA_TO_OFFSET, 32'h1010);
        query(sat_pkg::CMD_RVA_TO_MAPPED, 32'h0);
        query(sat_pkg::CMD_OFFSET_TO_RVA, 32'h400);
        query(sat_pkg::CMD_MAPPED_TO_RVA, 32'h3FF);
        query(sat_pkg::CMD_SECTION_START, 32'hFFFF_FFFF);
        query(sat_pkg::CMD_RAW_TOTAL, 32'h5000);
        query(sat_pkg::CMD_RVA_TO_OFFSET, 32'hFFFF_FFFF);
        query(sat_pkg::CMD_OFFSET_TO_RVA, 32'h0);
        drain();

        // count above the table size
        cfg_write(sat_pkg::REG_SECTION_COUNT, 31);
        query(sat_pkg::CMD_SECTION_START, 32'h2FFF);
        query(sat_pkg::CMD_RAW_TOTAL, 32'hFFFF_F800);

        // random phases
        while (words_sent < TOTAL_WORDS)
        begin
            drain();
            quiet = (phase_count % 6 == 4);
            settle_registers(phase_count);
            build_image(phase_count % 5 == 3);
            for (int n = 0; n < PHASE_QUERIES; n++)
            begin
                if (n == 8 && (phase_count == 3 || phase_count == 11))
                    hold_asked++;
                random_word();
            end
            phase_count++;
        end

        drain();
        repeat (40) @(negedge clk);

        $display("summary: %0d words (%0d loads) in %0d register phases, %0d results compared",
                 words_sent, loads_sent, phase_count, checked);
        $display("summary: counts 0 to 31, mapping base extremes, %0d hold-offs of %0d cycles",
                 hold_done, HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("tb_section_address_translator: clean");
        else
        begin
            if (pending != 0)
                $display("%0d expected results never arrived", pending);
            $display("tb_section_address_translator: errors");
        end
        $finish;
    end

endmodule
